// File: rtl/core/quaternion_vector_rotation_macros.svh
// assertion macros for the rotation pipeline
`ifndef QUATERNION_VECTOR_ROTATION_MACROS_SVH
`define QUATERNION_VECTOR_ROTATION_MACROS_SVH

// same-cycle implication
`define QVR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qvr check failed");

// next-cycle implication
`define QVR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qvr check failed");

`endif

// File: rtl/core/qvr_pkg.sv
package qvr_pkg;
  localparam int QUAT_WIDTH_DEF = 16;
  localparam int VEC_WIDTH_DEF  = 16;
endpackage

// File: rtl/core/qvr_if.sv
interface qvr_in_if #(
  parameter int QW = qvr_pkg::QUAT_WIDTH_DEF,
  parameter int VW = qvr_pkg::VEC_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] quat_w;
  logic signed [QW-1:0] quat_x;
  logic signed [QW-1:0] quat_y;
  logic signed [QW-1:0] quat_z;
  logic signed [VW-1:0] vec_x;
  logic signed [VW-1:0] vec_y;
  logic signed [VW-1:0] vec_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                  input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                output ready);
endinterface

interface qvr_out_if #(
  parameter int VW = qvr_pkg::VEC_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] rot_x;
  logic signed [VW-1:0] rot_y;
  logic signed [VW-1:0] rot_z;
  logic                 zero_quat;
  logic                 clipped;
  modport source (output valid, rot_x, rot_y, rot_z, zero_quat, clipped, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, zero_quat, clipped, output ready);
endinterface

// File: rtl/core/quaternion_vector_rotation.sv
// Rotates a vector by a quaternion: rot = vec part of q*(0,v)*conj(q)/|q|^2, exact
// integer numerator, one rounded (half away from zero) division by the squared norm,
// saturated to VEC_WIDTH bits with a clipped flag; an all-zero quaternion gives zero
// output with zero_quat set. Fully pipelined: one request accepted every cycle unless
// the output stalls (two stages build the rotation matrix, three multiply, sum and
// prepare the dividend, VEC_WIDTH+2 restoring division steps of one quotient bit each,
// one output register). A stall at the output freezes the whole pipe; in_ch.ready is
// high whenever the output register is empty or being taken.
module quaternion_vector_rotation #(
  parameter int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH_DEF,
  parameter int VEC_WIDTH  = qvr_pkg::VEC_WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  qvr_in_if.sink    in_ch,
  qvr_out_if.source out_ch
);
  import qvr_pkg::*;
  `include "quaternion_vector_rotation_macros.svh"

  localparam int QW = QUAT_WIDTH;
  localparam int VW = VEC_WIDTH;
  localparam int CW = 2*QW + 2;
  localparam int NW = CW + VW + 2;
  localparam int RW = NW + 2;
  localparam int DW = 2*QW + 2;
  // quotient is below 2^(VW+1) plus rounding
  localparam int QB = VW + 2;
  localparam logic [QB-1:0] LIM = QB'(1) << (VW - 1);

  // global advance: the pipe moves whenever the output slot frees up
  logic en;

  logic                           c_valid, c_zero;
  logic signed [2:0][2:0][CW-1:0] c_coef;
  logic [2*QW:0]                  c_norm;
  logic signed [2:0][VW-1:0]      c_vec;

  // division chain taps, index 0 is the dividend from the mac stage
  logic [QB:0]                d_valid, d_zero;
  logic [QB:0][2:0][RW-1:0]   d_rem;
  logic [QB:0][2:0][QB-1:0]   d_quo;
  logic [QB:0][2:0]           d_neg;
  logic [QB:0][DW-1:0]        d_den;

  logic                       out_valid_r;
  logic signed [2:0][VW-1:0]  rot_r, rot_nxt;
  logic                       zero_r, clip_r, clip_nxt;

  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  qvr_coef #(.QW(QW), .VW(VW)) u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_ch.valid),
    .w_i     (in_ch.quat_w),
    .x_i     (in_ch.quat_x),
    .y_i     (in_ch.quat_y),
    .z_i     (in_ch.quat_z),
    .vec_i   ({in_ch.vec_z, in_ch.vec_y, in_ch.vec_x}),
    .valid_o (c_valid),
    .coef_o  (c_coef),
    .norm_o  (c_norm),
    .vec_o   (c_vec),
    .zero_o  (c_zero)
  );

  qvr_mac #(.QW(QW), .VW(VW)) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (c_valid),
    .coef_i  (c_coef),
    .norm_i  (c_norm),
    .vec_i   (c_vec),
    .zero_i  (c_zero),
    .valid_o (d_valid[0]),
    .rem_o   (d_rem[0]),
    .neg_o   (d_neg[0]),
    .den_o   (d_den[0]),
    .zero_o  (d_zero[0])
  );

  assign d_quo[0] = '0;

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_div
    qvr_div_step #(.RW(RW), .DW(DW), .QB(QB), .STEP(QB - 1 - k)) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (d_valid[k]),
      .rem_i   (d_rem[k]),
      .quo_i   (d_quo[k]),
      .neg_i   (d_neg[k]),
      .den_i   (d_den[k]),
      .zero_i  (d_zero[k]),
      .valid_o (d_valid[k+1]),
      .rem_o   (d_rem[k+1]),
      .quo_o   (d_quo[k+1]),
      .neg_o   (d_neg[k+1]),
      .den_o   (d_den[k+1]),
      .zero_o  (d_zero[k+1])
    );
  end

  // saturation and sign restore
  always_comb begin
    clip_nxt = 1'b0;
    for (int r = 0; r < 3; r++) begin
      if (!d_neg[QB][r]) begin
        if (d_quo[QB][r] > LIM - QB'(1)) begin
          clip_nxt   = 1'b1;
          rot_nxt[r] = VW'(LIM - QB'(1));
        end else begin
          rot_nxt[r] = VW'(d_quo[QB][r]);
        end
      end else begin
        if (d_quo[QB][r] > LIM) begin
          clip_nxt   = 1'b1;
          rot_nxt[r] = VW'(-LIM);
        end else begin
          rot_nxt[r] = VW'(-d_quo[QB][r]);
        end
      end
    end
    // zero quaternion overrides whatever the divider made of n = 0
    if (d_zero[QB]) begin
      clip_nxt = 1'b0;
      rot_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r  <= rot_nxt;
      zero_r <= d_zero[QB];
      clip_r <= clip_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.rot_x     = rot_r[0];
  assign out_ch.rot_y     = rot_r[1];
  assign out_ch.rot_z     = rot_r[2];
  assign out_ch.zero_quat = zero_r;
  assign out_ch.clipped   = clip_r;

  // a zero quaternion never reports clipping and always yields a zero vector
  `QVR_ASSERT_IMPL(a_zero_out, out_valid_r && zero_r, !clip_r && rot_r == '0)
  // a clipped result carries at least one limit value
  `QVR_ASSERT_IMPL(a_clip_lim, out_valid_r && clip_r,
    rot_r[0] == VW'(LIM - QB'(1)) || rot_r[0] == VW'(-LIM) ||
    rot_r[1] == VW'(LIM - QB'(1)) || rot_r[1] == VW'(-LIM) ||
    rot_r[2] == VW'(LIM - QB'(1)) || rot_r[2] == VW'(-LIM))
  // a stall freezes the last divider stage
  `QVR_ASSERT_NEXT(a_stall_hold, !en, $stable(d_valid[QB]))
endmodule

// File: rtl/core/qvr_coef.sv
module qvr_coef #(
  parameter int QW = 16,
  parameter int VW = 16,
  localparam int CW = 2*QW + 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           valid_i,
  input  logic signed [QW-1:0]           w_i,
  input  logic signed [QW-1:0]           x_i,
  input  logic signed [QW-1:0]           y_i,
  input  logic signed [QW-1:0]           z_i,
  input  logic signed [2:0][VW-1:0]      vec_i,
  output logic                           valid_o,
  output logic signed [2:0][2:0][CW-1:0] coef_o,
  output logic [2*QW:0]                  norm_o,
  output logic signed [2:0][VW-1:0]      vec_o,
  output logic                           zero_o
);
  // pair products: ww xx yy zz xy xz yz wx wy wz
  logic signed [9:0][2*QW-1:0] prod_r;
  logic signed [2:0][VW-1:0]   vec1_r;
  logic                        zero1_r, valid1_r;
  logic signed [2:0][2:0][CW-1:0] coef_r;
  logic [2*QW:0]               norm_r;
  logic signed [2:0][VW-1:0]   vec2_r;
  logic                        zero2_r, valid2_r;
  logic signed [CW-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else if (en) begin
      valid1_r <= valid_i;
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0] <= w_i * w_i;
      prod_r[1] <= x_i * x_i;
      prod_r[2] <= y_i * y_i;
      prod_r[3] <= z_i * z_i;
      prod_r[4] <= x_i * y_i;
      prod_r[5] <= x_i * z_i;
      prod_r[6] <= y_i * z_i;
      prod_r[7] <= w_i * x_i;
      prod_r[8] <= w_i * y_i;
      prod_r[9] <= w_i * z_i;
      vec1_r    <= vec_i;
      zero1_r   <= (w_i == '0) && (x_i == '0) && (y_i == '0) && (z_i == '0);
    end
  end

  // elements of a packed array are unsigned, so sign extend explicitly
  assign ww = CW'($signed(prod_r[0]));
  assign xx = CW'($signed(prod_r[1]));
  assign yy = CW'($signed(prod_r[2]));
  assign zz = CW'($signed(prod_r[3]));
  assign xy = CW'($signed(prod_r[4]));
  assign xz = CW'($signed(prod_r[5]));
  assign yz = CW'($signed(prod_r[6]));
  assign wx = CW'($signed(prod_r[7]));
  assign wy = CW'($signed(prod_r[8]));
  assign wz = CW'($signed(prod_r[9]));

  always_ff @(posedge clk) begin
    if (en) begin
      coef_r[0][0] <= ww + xx - yy - zz;
      coef_r[0][1] <= (xy - wz) <<< 1;
      coef_r[0][2] <= (xz + wy) <<< 1;
      coef_r[1][0] <= (xy + wz) <<< 1;
      coef_r[1][1] <= ww + yy - zz - xx;
      coef_r[1][2] <= (yz - wx) <<< 1;
      coef_r[2][0] <= (xz - wy) <<< 1;
      coef_r[2][1] <= (yz + wx) <<< 1;
      coef_r[2][2] <= ww + zz - xx - yy;
      norm_r       <= (2*QW+1)'(ww + xx + yy + zz);
      vec2_r       <= vec1_r;
      zero2_r      <= zero1_r;
    end
  end

  assign valid_o = valid2_r;
  assign coef_o  = coef_r;
  assign norm_o  = norm_r;
  assign vec_o   = vec2_r;
  assign zero_o  = zero2_r;
endmodule

// File: rtl/core/qvr_mac.sv
module qvr_mac #(
  parameter int QW = 16,
  parameter int VW = 16,
  localparam int CW = 2*QW + 2,
  localparam int PW = CW + VW,
  localparam int NW = PW + 2,
  localparam int RW = NW + 2,
  localparam int DW = 2*QW + 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           valid_i,
  input  logic signed [2:0][2:0][CW-1:0] coef_i,
  input  logic [2*QW:0]                  norm_i,
  input  logic signed [2:0][VW-1:0]      vec_i,
  input  logic                           zero_i,
  output logic                           valid_o,
  output logic [2:0][RW-1:0]             rem_o,
  output logic [2:0]                     neg_o,
  output logic [DW-1:0]                  den_o,
  output logic                           zero_o
);
  logic signed [2:0][2:0][PW-1:0] prod_r;
  logic [2*QW:0]                  norm3_r, norm4_r;
  logic                           zero3_r, zero4_r, zero5_r;
  logic signed [2:0][NW-1:0]      num_r;
  logic [2:0][RW-1:0]             rem_r;
  logic [2:0]                     neg_r;
  logic [DW-1:0]                  den_r;
  logic [2:0]                     valid_r;
  logic [2:0][NW-1:0]             mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[1:0], valid_i};
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mag[r] = num_r[r][NW-1] ? NW'(-num_r[r]) : NW'(num_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= PW'($signed(coef_i[r][c])) * PW'($signed(vec_i[c]));
        end
        num_r[r] <= NW'($signed(prod_r[r][0])) + NW'($signed(prod_r[r][1])) +
                    NW'($signed(prod_r[r][2]));
        // rounding: floor((2|num| + n) / 2n)
        rem_r[r] <= (RW'(mag[r]) << 1) + RW'(norm4_r);
        neg_r[r] <= num_r[r][NW-1];
      end
      den_r   <= DW'(norm4_r) << 1;
      norm3_r <= norm_i;
      norm4_r <= norm3_r;
      zero3_r <= zero_i;
      zero4_r <= zero3_r;
      zero5_r <= zero4_r;
    end
  end

  assign valid_o = valid_r[2];
  assign rem_o   = rem_r;
  assign neg_o   = neg_r;
  assign den_o   = den_r;
  assign zero_o  = zero5_r;
endmodule

// File: rtl/core/qvr_div_step.sv
module qvr_div_step #(
  parameter int RW   = 54,
  parameter int DW   = 34,
  parameter int QB   = 18,
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic [2:0][RW-1:0]   rem_i,
  input  logic [2:0][QB-1:0]   quo_i,
  input  logic [2:0]           neg_i,
  input  logic [DW-1:0]        den_i,
  input  logic                 zero_i,
  output logic                 valid_o,
  output logic [2:0][RW-1:0]   rem_o,
  output logic [2:0][QB-1:0]   quo_o,
  output logic [2:0]           neg_o,
  output logic [DW-1:0]        den_o,
  output logic                 zero_o
);
  logic [RW-1:0] dsh;
  logic          valid_r;
  logic [2:0][RW-1:0] rem_r;
  logic [2:0][QB-1:0] quo_r;
  logic [2:0]    neg_r;
  logic [DW-1:0] den_r;
  logic          zero_r;

  assign dsh = RW'(den_i) << STEP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        if (rem_i[r] >= dsh) begin
          rem_r[r] <= rem_i[r] - dsh;
          quo_r[r] <= quo_i[r] | (QB'(1) << STEP);
        end else begin
          rem_r[r] <= rem_i[r];
          quo_r[r] <= quo_i[r];
        end
      end
      neg_r  <= neg_i;
      den_r  <= den_i;
      zero_r <= zero_i;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign quo_o   = quo_r;
  assign neg_o   = neg_r;
  assign den_o   = den_r;
  assign zero_o  = zero_r;
endmodule
